// File: rtl/cssl_pkg.sv
// Shared types, constants and helpers for the channel statistics and sorted list unit.
// Has no dependencies; cssl_cmp, cssl_stats and the top level import it.
package cssl_pkg;

    localparam int MAX_NETS    = 64;
    localparam int CHANNEL_MAX = 13;

    localparam int STORE_DEPTH = MAX_NETS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_NETS + 1);
    localparam int STAT_IW     = (CHANNEL_MAX > 1) ? $clog2(CHANNEL_MAX) : 1;

    localparam logic [3:0]        CH_MAX_V  = 4'(CHANNEL_MAX);
    localparam logic signed [7:0] NO_SIGNAL = -8'sd127;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_SORT  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_BAD_CH   = 3'd1,
        ST_FULL     = 3'd2,
        ST_RECORD   = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_STATS    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET_E,
        S_CMP,
        S_PLACE,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]        op;
        logic [3:0]        channel;
        logic signed [7:0] rssi;
        logic              is_open;
        logic [7:0]        tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        rec_channel;
        logic signed [7:0] rec_rssi;
        logic [7:0]        rec_tag;
        logic              last;
        logic [6:0]        ch_count;
        logic [6:0]        ch_open_count;
        logic signed [7:0] ch_best_rssi;
        logic [6:0]        max_count;
    } t_out_item;

    typedef struct packed {
        logic [3:0]        channel;
        logic signed [7:0] rssi;
        logic [7:0]        tag;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic               clr;
        logic               add;
        logic [STAT_IW-1:0] idx;
        logic               is_open;
        logic signed [7:0]  rssi;
    } t_stat_upd;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  open_count;
        logic signed [7:0] best;
        logic [CNT_W-1:0]  max_count;
    } t_stat_rd;

    function automatic logic chan_ok(input logic [3:0] ch);
        return (ch != 4'd0) && (ch <= CH_MAX_V);
    endfunction

    function automatic logic [STAT_IW-1:0] stat_idx(input logic [3:0] ch);
        logic [3:0] k;
        k = ch - 4'd1;
        return k[STAT_IW-1:0];
    endfunction

endpackage

// File: rtl/cssl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module cssl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cssl_cmp.sv
// Record order compare: true when the stored record must move behind the held one.
// Depends on cssl_pkg for the record type.
module cssl_cmp (
    input  cssl_pkg::t_rec i_stored,
    input  cssl_pkg::t_rec i_held,
    output logic           o_after
);
    import cssl_pkg::*;

    assign o_after = (i_stored.channel > i_held.channel) ||
                     ((i_stored.channel == i_held.channel) && (i_stored.rssi < i_held.rssi));

endmodule

// File: rtl/cssl_stats.sv
// Per-channel statistics registers: network count, open count, best signal, largest count.
// Depends on cssl_pkg for the update and read structs.
module cssl_stats (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cssl_pkg::t_stat_upd  i_upd,
    output cssl_pkg::t_stat_rd   o_rd
);
    import cssl_pkg::*;

    logic [CNT_W-1:0]  r_cnt  [CHANNEL_MAX];
    logic [CNT_W-1:0]  r_opn  [CHANNEL_MAX];
    logic signed [7:0] r_best [CHANNEL_MAX];
    logic [CNT_W-1:0]  r_max;
    logic [CNT_W-1:0]  cnt_inc;

    assign cnt_inc = r_cnt[i_upd.idx] + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_upd.clr) begin
            for (int k = 0; k < CHANNEL_MAX; k++) begin
                r_cnt[k]  <= '0;
                r_opn[k]  <= '0;
                r_best[k] <= NO_SIGNAL;
            end
            r_max <= CNT_W'(1);
        end else if (i_upd.add) begin
            r_cnt[i_upd.idx] <= cnt_inc;
            if (i_upd.is_open) begin
                r_opn[i_upd.idx] <= r_opn[i_upd.idx] + CNT_W'(1);
            end
            if (i_upd.rssi > r_best[i_upd.idx]) begin
                r_best[i_upd.idx] <= i_upd.rssi;
            end
            if (cnt_inc > r_max) begin
                r_max <= cnt_inc;
            end
        end
    end

    always_comb begin
        o_rd.count      = r_cnt[i_upd.idx];
        o_rd.open_count = r_opn[i_upd.idx];
        o_rd.best       = r_best[i_upd.idx];
        o_rd.max_count  = r_max;
    end

endmodule

// File: rtl/channel_stats_and_sorted_list_unit.sv
// Channel statistics and sorted scan list, top level with the command sequencer.
// Depends on cssl_pkg, cssl_ram, cssl_cmp and cssl_stats.
//
// Add and query each answer through a one-entry output register (clear gives no
// answer), so a new command is taken as soon as that register is free. A sort
// request runs an in-place insertion sort over the record RAM through its single
// read and single write port, paced by the one record compare unit, then reads
// the records out in order, each record leaving as the output register frees.
// The input is stalled for the whole sort and emit run.
module channel_stats_and_sorted_list_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cssl_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cssl_pkg::t_out_item  o_out_data
);
    import cssl_pkg::*;

    t_state               r_state, n_state;
    logic [STORE_AW-1:0]  r_i, n_i;
    logic [STORE_AW-1:0]  r_j, n_j;
    t_rec                 r_e, n_e;
    logic [CNT_W-1:0]     r_stored, n_stored;
    logic [CNT_W-1:0]     r_offered, n_offered;
    logic                 r_ovalid, n_ovalid;
    t_out_item            r_odata, n_odata;

    logic                 can_load, acc, ld, after, i_last;
    t_out_item            ld_data;
    logic                 we;
    logic [STORE_AW-1:0]  waddr, raddr;
    t_rec                 wdata, rdata;
    t_stat_upd            upd;
    t_stat_rd             srd;
    t_rec                 in_rec;

    cssl_ram #(
        .WIDTH (REC_W),
        .DEPTH (STORE_DEPTH),
        .AW    (STORE_AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cssl_cmp u_cmp (
        .i_stored (rdata),
        .i_held   (r_e),
        .o_after  (after)
    );

    cssl_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_rd    (srd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stored  <= '0;
            r_offered <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_stored  <= n_stored;
            r_offered <= n_offered;
            r_ovalid  <= n_ovalid;
        end
        r_i     <= n_i;
        r_j     <= n_j;
        r_e     <= n_e;
        r_odata <= n_odata;
    end

    assign can_load    = !r_ovalid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !can_load;
    assign acc         = i_in_valid && !o_in_stall;
    assign i_last      = ({1'b0, r_i} + CNT_W'(1)) == r_stored;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    always_comb begin
        in_rec.channel = i_in_data.channel;
        in_rec.rssi    = i_in_data.rssi;
        in_rec.tag     = i_in_data.tag;
    end

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_e       = r_e;
        n_stored  = r_stored;
        n_offered = r_offered;
        we        = 1'b0;
        waddr     = r_j;
        wdata     = r_e;
        raddr     = r_i;
        ld        = 1'b0;
        ld_data   = '0;
        ld_data.last = 1'b1;
        upd.clr     = 1'b0;
        upd.add     = 1'b0;
        upd.idx     = stat_idx(i_in_data.channel);
        upd.is_open = i_in_data.is_open;
        upd.rssi    = i_in_data.rssi;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (t_op'(i_in_data.op))
                        OP_CLEAR: begin
                            n_stored  = '0;
                            n_offered = '0;
                            upd.clr   = 1'b1;
                        end
                        OP_ADD: begin
                            ld = 1'b1;
                            if (r_offered >= CNT_W'(MAX_NETS)) begin
                                ld_data.status = ST_FULL;
                            end else begin
                                n_offered = r_offered + CNT_W'(1);
                                if (!chan_ok(i_in_data.channel)) begin
                                    ld_data.status = ST_BAD_CH;
                                end else begin
                                    we       = 1'b1;
                                    waddr    = r_stored[STORE_AW-1:0];
                                    wdata    = in_rec;
                                    n_stored = r_stored + CNT_W'(1);
                                    upd.add  = 1'b1;
                                    ld_data.status = ST_ACCEPTED;
                                end
                            end
                        end
                        OP_SORT: begin
                            if (r_stored == '0) begin
                                ld = 1'b1;
                                ld_data.status = ST_EMPTY;
                            end else if (r_stored == CNT_W'(1)) begin
                                n_i     = '0;
                                n_state = S_EMIT_RD;
                            end else begin
                                n_i     = STORE_AW'(1);
                                raddr   = STORE_AW'(1);
                                n_state = S_GET_E;
                            end
                        end
                        OP_QUERY: begin
                            ld = 1'b1;
                            ld_data.status    = ST_STATS;
                            ld_data.max_count = 7'(srd.max_count);
                            if (chan_ok(i_in_data.channel)) begin
                                ld_data.ch_count      = 7'(srd.count);
                                ld_data.ch_open_count = 7'(srd.open_count);
                                ld_data.ch_best_rssi  = srd.best;
                            end else begin
                                ld_data.ch_best_rssi  = NO_SIGNAL;
                            end
                        end
                        default: begin
                            ld = 1'b0;
                        end
                    endcase
                end
            end
            S_GET_E: begin
                n_e     = rdata;
                n_j     = r_i;
                raddr   = r_i - STORE_AW'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (after) begin
                    we    = 1'b1;
                    waddr = r_j;
                    wdata = rdata;
                    n_j   = r_j - STORE_AW'(1);
                    raddr = r_j - STORE_AW'(2);
                    if (r_j == STORE_AW'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                we    = 1'b1;
                waddr = r_j;
                wdata = r_e;
                if (i_last) begin
                    n_i     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_i     = r_i + STORE_AW'(1);
                    raddr   = r_i + STORE_AW'(1);
                    n_state = S_GET_E;
                end
            end
            S_EMIT_RD: begin
                raddr   = r_i;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                raddr = r_i;
                if (can_load) begin
                    ld = 1'b1;
                    ld_data.status      = ST_RECORD;
                    ld_data.rec_channel = rdata.channel;
                    ld_data.rec_rssi    = rdata.rssi;
                    ld_data.rec_tag     = rdata.tag;
                    ld_data.last        = i_last;
                    if (i_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i   = r_i + STORE_AW'(1);
                        raddr = r_i + STORE_AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovalid = r_ovalid && i_out_stall;
        n_odata  = r_odata;
        if (ld) begin
            n_ovalid = 1'b1;
            n_odata  = ld_data;
        end
    end

endmodule
